// ===== design/lrmnd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrmnd_pkg: shared types and constants
// Beat formats, configuration register codes and the register bank struct
// for the lidar recursive mean filter with near detection.
// ----------------------------------------------------------------------------
package lrmnd_pkg;

  // Field widths fixed by the beat formats.
  localparam int RANGE_W     = 16;
  localparam int INDEX_W     = 12;
  localparam int ANGLE_W     = 22;
  localparam int STEP_W      = 16;
  localparam int LENGTH_W    = 13;
  localparam int ACC_W       = 28;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_SEL_W   = 3;

  // Register reset values.
  localparam logic [LENGTH_W-1:0]       RST_SCAN_LENGTH    = 13'd720;
  localparam logic signed [ANGLE_W-1:0] RST_START_ANGLE    = 22'sd0;
  localparam logic signed [STEP_W-1:0]  RST_ANGLE_STEP     = 16'sd2048;
  localparam logic signed [ANGLE_W-1:0] RST_WINDOW_LOW     = 22'sd4096;
  localparam logic signed [ANGLE_W-1:0] RST_WINDOW_HIGH    = 22'sd6144;
  localparam logic [RANGE_W-1:0]        RST_NEAR_THRESHOLD = 16'd100;

  // Register index, taken from the word address.
  typedef enum logic [REG_SEL_W-1:0] {
    REG_SCAN_LENGTH    = 3'd0,
    REG_START_ANGLE    = 3'd1,
    REG_ANGLE_STEP     = 3'd2,
    REG_WINDOW_LOW     = 3'd3,
    REG_WINDOW_HIGH    = 3'd4,
    REG_NEAR_THRESHOLD = 3'd5
  } reg_sel_t;

  // Register bank contents as seen by the datapath.
  typedef struct packed {
    logic [LENGTH_W-1:0]       scan_length;
    logic signed [ANGLE_W-1:0] start_angle;
    logic signed [STEP_W-1:0]  angle_step;
    logic signed [ANGLE_W-1:0] window_low;
    logic signed [ANGLE_W-1:0] window_high;
    logic [RANGE_W-1:0]        near_threshold;
  } lrmnd_cfg_t;

  // Input beat: one range sample.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [INDEX_W-1:0] sample_index;
    logic [RANGE_W-1:0] filtered_mm;
    logic               obstacle;
  } out_beat_t;

endpackage

// ===== design/lrmnd_stream_if.sv =====
// ----------------------------------------------------------------------------
// lrmnd_stream_if: valid/ready stream channel
// Carries one payload beat per handshake; a beat moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface lrmnd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/lidar_recursive_mean_near_detect.sv =====
// ----------------------------------------------------------------------------
// lidar_recursive_mean_near_detect: recursive mean filter with near detection
// Filters the range samples of a lidar scan with a ten point recursive mean,
// tracks the sample angle and flags near obstacles inside an angle window.
//
// Channel   Direction  Beat contents
// in_s      in         range_mm
// out_s     out        sample_index, filtered_mm, obstacle
// APB       in/out     six configuration registers at byte address 4*i
//
// One sample is accepted every cycle unless a stalled result is held; its
// result, if any, is registered and shows on out_s in the following cycle.
// The history sum and reciprocal multiply for the mean are combinational.
// Reset (rst_n low, synchronous) empties the history, zeroes the sample index
// and loads the register reset values. A stalled result blocks only while it
// is still held; in_s.ready stays high whenever out_s can take the next beat.
// ----------------------------------------------------------------------------
module lidar_recursive_mean_near_detect
  import lrmnd_pkg::*;
#(
  parameter int HISTORY_TAPS = 9,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lrmnd_stream_if.sink          in_s,
  lrmnd_stream_if.source        out_s,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // History depth: the mean taps plus two more cells.
  localparam int CELLS   = HISTORY_TAPS + 2;
  localparam int DIV_N   = HISTORY_TAPS + 1;
  localparam int SUM_W   = RANGE_W + $clog2(DIV_N);
  localparam int SHIFT   = SUM_W + $clog2(DIV_N);
  localparam int PROD_W  = 2 * SUM_W + 1;
  // Rounded-up reciprocal; exact for every sum below 2**SUM_W.
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + DIV_N - 1) / DIV_N;
  localparam logic [SUM_W:0]  RECIP   = RECIP_L[SUM_W:0];
  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W   = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_SAMPLES);

  lrmnd_cfg_t cfg;

  logic [RANGE_W-1:0]      tap_q [CELLS];
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        sum_nxt;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        idx_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_beat_t               out_beat_r;
  out_beat_t               out_beat_nxt;

  logic                    in_ready;
  logic                    in_fire;
  logic [SUM_W-1:0]        total;
  logic [PROD_W-1:0]       prod;
  logic [RANGE_W-1:0]      filt;
  logic                    near;
  logic signed [ACC_W-1:0] angle_cur;
  logic signed [ACC_W-1:0] win_lo;
  logic signed [ACC_W-1:0] win_hi;
  logic                    in_window;
  logic [CMP_W-1:0]        len_raw;
  logic [CMP_W-1:0]        len_eff;
  logic [CMP_W-1:0]        idx_inc;
  logic                    scan_end;

  // Register bank.
  lrmnd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: take a sample whenever the result register is free or drains.
  assign in_ready   = !out_valid_r || out_s.ready;
  assign in_fire    = in_s.valid && in_ready;
  assign in_s.ready = in_ready;

  // Chain of history cells, newest value in cell zero.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    lrmnd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (in_fire),
      .clear (in_fire && scan_end),
      .d_in  ((k == 0) ? filt : tap_q[(k == 0) ? 0 : k - 1]),
      .q     (tap_q[k])
    );
  end

  // Mean: the running sum of the mean taps plus the new sample, times the
  // reciprocal of the mean taps plus one.
  assign total = sum_r + SUM_W'(in_s.payload.range_mm);
  assign prod  = PROD_W'(total) * PROD_W'(RECIP);
  assign filt  = prod[SHIFT +: RANGE_W];

  // Keep the running sum in step with the cells: add the new value and drop
  // the one that leaves the mean taps.
  assign sum_nxt = sum_r + SUM_W'(filt) - SUM_W'(tap_q[HISTORY_TAPS-1]);

  // Near test over this value and the two before it.
  assign near = (filt < cfg.near_threshold) && (tap_q[0] < cfg.near_threshold) &&
                (tap_q[1] < cfg.near_threshold);

  // Sample angle and window check.
  assign angle_cur = (idx_r == '0) ? ACC_W'(cfg.start_angle) : acc_r;
  assign acc_nxt   = angle_cur + ACC_W'(cfg.angle_step);
  assign win_lo    = ACC_W'(cfg.window_low);
  assign win_hi    = ACC_W'(cfg.window_high);
  assign in_window = (angle_cur >= win_lo) && (angle_cur <= win_hi);

  // Effective scan length, at least one and at most the sample limit.
  assign len_raw = CMP_W'(cfg.scan_length);
  always_comb begin
    priority if (len_raw == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_raw > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = len_raw;
    end
  end

  assign idx_inc  = CMP_W'(idx_r) + CMP_W'(1);
  assign scan_end = (idx_inc >= len_eff);
  assign idx_nxt  = scan_end ? '0 : idx_inc[IDX_W-1:0];

  // Result register next state.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (in_fire) begin
      out_valid_nxt = in_window;
      out_beat_nxt.sample_index = INDEX_W'(idx_r);
      out_beat_nxt.filtered_mm  = filt;
      out_beat_nxt.obstacle     = near;
    end else if (out_s.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and sample state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      idx_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        sum_r <= scan_end ? '0 : sum_nxt;
        idx_r <= idx_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_s.valid   = out_valid_r;
  assign out_s.payload = out_beat_r;

endmodule

// ===== design/lrmnd_cell.sv =====
// ----------------------------------------------------------------------------
// lrmnd_cell: one history cell
// Holds one past filtered value and passes it to the next cell on each
// accepted sample; cleared at reset and at the end of each scan.
// ----------------------------------------------------------------------------
module lrmnd_cell
  import lrmnd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift,
  input  logic               clear,
  input  logic [RANGE_W-1:0] d_in,
  output logic [RANGE_W-1:0] q
);

  logic [RANGE_W-1:0] val_r;
  logic [RANGE_W-1:0] val_nxt;

  // Clearing wins over shifting, so a new scan starts from an empty history.
  always_comb begin
    val_nxt = val_r;
    if (clear) begin
      val_nxt = '0;
    end else if (shift) begin
      val_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

// ===== design/lrmnd_regs.sv =====
// ----------------------------------------------------------------------------
// lrmnd_regs: configuration register bank
// APB-style write and read access to the six configuration registers, one
// per 32-bit word.
// ----------------------------------------------------------------------------
module lrmnd_regs
  import lrmnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output lrmnd_cfg_t            cfg
);

  lrmnd_cfg_t cfg_r;
  lrmnd_cfg_t cfg_nxt;
  reg_sel_t   sel;
  logic       wr_en;

  assign pready = 1'b1;
  assign sel    = reg_sel_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode; words past the last register are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (sel)
        REG_SCAN_LENGTH:    cfg_nxt.scan_length    = pwdata[LENGTH_W-1:0];
        REG_START_ANGLE:    cfg_nxt.start_angle    = pwdata[ANGLE_W-1:0];
        REG_ANGLE_STEP:     cfg_nxt.angle_step     = pwdata[STEP_W-1:0];
        REG_WINDOW_LOW:     cfg_nxt.window_low     = pwdata[ANGLE_W-1:0];
        REG_WINDOW_HIGH:    cfg_nxt.window_high    = pwdata[ANGLE_W-1:0];
        REG_NEAR_THRESHOLD: cfg_nxt.near_threshold = pwdata[RANGE_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_length    <= RST_SCAN_LENGTH;
      cfg_r.start_angle    <= RST_START_ANGLE;
      cfg_r.angle_step     <= RST_ANGLE_STEP;
      cfg_r.window_low     <= RST_WINDOW_LOW;
      cfg_r.window_high    <= RST_WINDOW_HIGH;
      cfg_r.near_threshold <= RST_NEAR_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the raw register bits, zero extended.
  always_comb begin
    unique case (sel)
      REG_SCAN_LENGTH:    prdata = CFG_DATA_W'(cfg_r.scan_length);
      REG_START_ANGLE:    prdata = CFG_DATA_W'(unsigned'(cfg_r.start_angle));
      REG_ANGLE_STEP:     prdata = CFG_DATA_W'(unsigned'(cfg_r.angle_step));
      REG_WINDOW_LOW:     prdata = CFG_DATA_W'(unsigned'(cfg_r.window_low));
      REG_WINDOW_HIGH:    prdata = CFG_DATA_W'(unsigned'(cfg_r.window_high));
      REG_NEAR_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.near_threshold);
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== sim/lidar_recursive_mean_near_detect_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_recursive_mean_near_detect_tb: self-checking bench for the scan filter
// Streams range samples through the block and predicts every result beat.
// It mirrors the recursive mean, the running angle and the near test, and
// compares each result beat field by field. Directed scans cover the reset
// settings, range and register extremes, scan restart, saturated and zero
// lengths, an empty window and a length cut mid-scan. Two long runs use a
// saturated length and the steepest falling step, and random settings follow
// with random idling on both channels.
// ----------------------------------------------------------------------------
module lidar_recursive_mean_near_detect_tb;
  import lrmnd_pkg::*;

  localparam int MEAN_TAPS      = 9;
  localparam int HIST_DEPTH     = MEAN_TAPS + 2;
  localparam int FULL_SCAN      = 4096;
  localparam int LONG_RUN       = 120;
  localparam int ANG_FIELD_MIN  = -2097152;
  localparam int ANG_FIELD_MAX  = 2097151;
  localparam int STEP_MIN       = -32768;
  localparam int STEP_MAX       = 32767;
  localparam int LENGTH_MAX     = 8191;
  localparam int RANGE_MAX      = 65535;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_SAMPLES = 1250;
  localparam int HOLD_PHASE     = 3;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lrmnd_stream_if #(.payload_t(in_beat_t))  in_if ();
  lrmnd_stream_if #(.payload_t(out_beat_t)) out_if ();

  lidar_recursive_mean_near_detect u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_if),
    .out_s   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the filter state and of the register bank.
  logic [RANGE_W-1:0]        filt_history [0:HIST_DEPTH-1];
  logic [LENGTH_W-1:0]       scan_pos;
  logic signed [ACC_W-1:0]   angle_acc;
  logic [LENGTH_W-1:0]       len_cfg;
  logic signed [ANGLE_W-1:0] start_cfg;
  logic signed [STEP_W-1:0]  step_cfg;
  logic signed [ANGLE_W-1:0] win_lo_cfg;
  logic signed [ANGLE_W-1:0] win_hi_cfg;
  logic [RANGE_W-1:0]        near_cfg;

  in_beat_t  range_queue[$];
  out_beat_t pending_results[$];

  int gap_left       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  int hold_served    = 0;
  int hold_requests  = 0;
  int in_idle_max    = 0;
  int out_idle_max   = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int obstacles_seen = 0;
  int reg_writes     = 0;
  int error_count    = 0;
  int idle_cycles    = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the filter mirror by one accepted range beat and queue its result.
  function automatic void filter_range(input logic [RANGE_W-1:0] range_in);
    int unsigned eff_len;
    int unsigned total;
    longint      angle;
    logic [RANGE_W-1:0] filt;
    out_beat_t   res;
    eff_len = len_cfg;
    if (eff_len == 0) eff_len = 1;
    if (eff_len > FULL_SCAN) eff_len = FULL_SCAN;
    angle = (scan_pos == 0) ? longint'(start_cfg) : longint'(angle_acc);
    total = range_in;
    for (int k = 0; k < MEAN_TAPS; k++) total += filt_history[k];
    filt = RANGE_W'(total / (MEAN_TAPS + 1));
    if (angle >= longint'(win_lo_cfg) && angle <= longint'(win_hi_cfg)) begin
      res.sample_index = scan_pos[INDEX_W-1:0];
      res.filtered_mm  = filt;
      res.obstacle     = (filt < near_cfg) && (filt_history[0] < near_cfg) &&
                         (filt_history[1] < near_cfg);
      pending_results.push_back(res);
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) filt_history[k] = filt_history[k-1];
    filt_history[0] = filt;
    angle_acc = ACC_W'(angle + longint'(step_cfg));
    scan_pos = scan_pos + 1'b1;
    if (scan_pos >= eff_len) begin
      scan_pos = '0;
      for (int k = 0; k < HIST_DEPTH; k++) filt_history[k] = '0;
    end
  endfunction

  // Range beat driver: offers queued beats, with a drawn gap after each one.
  always @(posedge clk) begin : range_driver
    int   gap;
    logic offer;
    gap   = gap_left;
    offer = in_if.valid;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left    <= 0;
      scan_pos    = '0;
      angle_acc   = '0;
      for (int k = 0; k < HIST_DEPTH; k++) filt_history[k] = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        filter_range(in_if.payload.range_mm);
        samples_sent++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap > 0) begin
          gap--;
        end else if (range_queue.size() != 0) begin
          in_if.payload <= range_queue.pop_front();
          offer = 1'b1;
          gap   = $urandom_range(0, in_idle_max);
        end
      end
      in_if.valid <= offer;
      gap_left    <= gap;
    end
  end

  // Result monitor: checks each result beat and paces out_if.ready.
  always @(posedge clk) begin : result_monitor
    out_beat_t got;
    out_beat_t want;
    int        stall;
    int        hold;
    stall = stall_left;
    hold  = hold_left;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      hold_served  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        results_seen++;
        if (got.obstacle) obstacles_seen++;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result beat: index %0d filtered %0d obstacle %0b",
                     got.sample_index, got.filtered_mm, got.obstacle);
        end else begin
          want = pending_results.pop_front();
          if (got.sample_index !== want.sample_index ||
              got.filtered_mm !== want.filtered_mm ||
              got.obstacle !== want.obstacle) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"result mismatch: expected index %0d filtered %0d obstacle %0b,",
                        " got index %0d filtered %0d obstacle %0b"},
                       want.sample_index, want.filtered_mm, want.obstacle,
                       got.sample_index, got.filtered_mm, got.obstacle);
          end
        end
        stall = $urandom_range(0, out_idle_max);
      end else if (stall > 0) begin
        stall--;
      end
      // A long hold-off lets the block fill up and stall its input.
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold = HOLD_CYCLES;
      end else if (hold > 0) begin
        hold--;
      end
      stall_left   <= stall;
      hold_left    <= hold;
      out_if.ready <= (stall == 0) && (hold == 0);
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One register write in a setup and an access phase; the mirror follows.
  task automatic write_reg(input reg_sel_t sel, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_SCAN_LENGTH:    len_cfg    = value[LENGTH_W-1:0];
      REG_START_ANGLE:    start_cfg  = value[ANGLE_W-1:0];
      REG_ANGLE_STEP:     step_cfg   = value[STEP_W-1:0];
      REG_WINDOW_LOW:     win_lo_cfg = value[ANGLE_W-1:0];
      REG_WINDOW_HIGH:    win_hi_cfg = value[ANGLE_W-1:0];
      REG_NEAR_THRESHOLD: near_cfg   = value[RANGE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // Wait until every queued beat is out and every expected result is in.
  task automatic drain_block();
    @(negedge clk);
    while (range_queue.size() != 0 || in_if.valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_range(input int value);
    range_queue.push_back('{range_mm: RANGE_W'(value)});
  endtask

  // Runs of near ranges, full-scale random ranges and extremes, so the near test gets deep.
  task automatic push_random_ranges(input int count);
    int left;
    int run;
    int mode;
    int near_top;
    left = count;
    near_top = (near_cfg == 0) ? 200 : int'(near_cfg);
    while (left > 0) begin
      run  = $urandom_range(3, 12);
      mode = $urandom_range(0, 9);
      if (run > left) run = left;
      repeat (run) begin
        if (mode < 5) push_range($urandom_range(0, near_top));
        else if (mode < 8) push_range($urandom_range(0, RANGE_MAX));
        else push_range($urandom_range(0, 1) ? RANGE_MAX : 0);
      end
      left -= run;
    end
  endtask

  function automatic int clamp_angle(input longint value);
    if (value < ANG_FIELD_MIN) return ANG_FIELD_MIN;
    if (value > ANG_FIELD_MAX) return ANG_FIELD_MAX;
    return int'(value);
  endfunction

  function automatic int pick_idle();
    return ($urandom_range(0, 9) < 3) ? 0 : 9;
  endfunction

  // Random settings for one phase: a new window, the other registers rewritten at random.
  task automatic randomize_settings();
    int     pick;
    int     value;
    longint a;
    longint b;
    pick = $urandom_range(0, 9);
    if (pick < 6) value = $urandom_range(10, 40);
    else if (pick < 7) value = $urandom_range(0, 9);
    else if (pick < 9) value = $urandom_range(41, 400);
    else value = $urandom_range(FULL_SCAN + 1, LENGTH_MAX);
    if ($urandom_range(0, 9) < 6) write_reg(REG_SCAN_LENGTH, value);

    pick = $urandom_range(0, 9);
    if (pick < 8) value = int'($urandom_range(0, 2949120)) - 1474560;
    else value = (pick == 8) ? ANG_FIELD_MIN : ANG_FIELD_MAX;
    if ($urandom_range(0, 9) < 6) write_reg(REG_START_ANGLE, value);

    pick = $urandom_range(0, 9);
    if (pick < 8) value = int'($urandom_range(0, 32768)) - 16384;
    else if (pick == 8) value = $urandom_range(0, 1) ? STEP_MAX : STEP_MIN;
    else value = 0;
    if ($urandom_range(0, 9) < 6) write_reg(REG_ANGLE_STEP, value);

    // Mostly a window around the first angles of a scan; sometimes none.
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      a = longint'(start_cfg) + longint'(step_cfg) * longint'($urandom_range(0, 40));
      b = longint'(start_cfg) + longint'(step_cfg) * longint'($urandom_range(0, 40));
      if (a > b) begin
        value = int'(a);
        a = b;
        b = value;
      end
      write_reg(REG_WINDOW_LOW, clamp_angle(a - longint'($urandom_range(0, 2048))));
      write_reg(REG_WINDOW_HIGH, clamp_angle(b + longint'($urandom_range(0, 2048))));
    end else if (pick < 8) begin
      write_reg(REG_WINDOW_LOW, ANG_FIELD_MIN);
      write_reg(REG_WINDOW_HIGH, ANG_FIELD_MAX);
    end else if (pick < 9) begin
      value = int'($urandom_range(0, 2949120)) - 1474560;
      write_reg(REG_WINDOW_LOW, value);
      write_reg(REG_WINDOW_HIGH, value - int'($urandom_range(1, 5000)));
    end else begin
      write_reg(REG_WINDOW_LOW, int'($urandom_range(0, 4194303)) + ANG_FIELD_MIN);
      write_reg(REG_WINDOW_HIGH, int'($urandom_range(0, 4194303)) + ANG_FIELD_MIN);
    end

    pick = $urandom_range(0, 9);
    if (pick < 5) value = $urandom_range(50, 2000);
    else if (pick < 7) value = 0;
    else if (pick < 8) value = RANGE_MAX;
    else value = $urandom_range(0, RANGE_MAX);
    if ($urandom_range(0, 9) < 6) write_reg(REG_NEAR_THRESHOLD, value);
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    int count;
    int phase;
    int random_sent;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_n         = 1'b0;
    len_cfg       = 720;
    start_cfg     = 0;
    step_cfg      = 2048;
    win_lo_cfg    = 4096;
    win_hi_cfg    = 6144;
    near_cfg      = 100;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: only the third and fourth samples fall in the window.
    in_idle_max  = 3;
    out_idle_max = 3;
    push_range(1000);
    push_range(2000);
    push_range(RANGE_MAX);
    push_range(0);
    drain_block();

    // Short scan over the widest window; near run, then far, then restart.
    write_reg(REG_SCAN_LENGTH, 8);
    write_reg(REG_START_ANGLE, ANG_FIELD_MIN);
    write_reg(REG_ANGLE_STEP, STEP_MAX);
    write_reg(REG_WINDOW_LOW, ANG_FIELD_MIN);
    write_reg(REG_WINDOW_HIGH, ANG_FIELD_MAX);
    write_reg(REG_NEAR_THRESHOLD, 100);
    push_range(0);
    push_range(0);
    push_range(0);
    repeat (5) push_range(RANGE_MAX);
    push_range(50);
    push_range(0);
    drain_block();

    // Zero length acts as one sample per scan; zero threshold never flags.
    write_reg(REG_SCAN_LENGTH, 0);
    write_reg(REG_NEAR_THRESHOLD, 0);
    write_reg(REG_ANGLE_STEP, STEP_MIN);
    write_reg(REG_START_ANGLE, ANG_FIELD_MAX);
    push_range(5);
    push_range(RANGE_MAX);
    push_range(0);
    drain_block();

    // Empty window gives no result at all.
    write_reg(REG_SCAN_LENGTH, 20);
    write_reg(REG_WINDOW_LOW, 100);
    write_reg(REG_WINDOW_HIGH, -100);
    push_range(7);
    push_range(9);
    drain_block();
    write_reg(REG_WINDOW_LOW, ANG_FIELD_MIN);
    write_reg(REG_WINDOW_HIGH, ANG_FIELD_MAX);
    write_reg(REG_NEAR_THRESHOLD, 300);
    push_range(20);
    push_range(40);
    push_range(60);
    drain_block();

    // Length cut below the current index ends the scan after one more sample.
    write_reg(REG_SCAN_LENGTH, 3);
    push_range(80);
    push_range(100);
    push_range(120);
    drain_block();
    write_reg(REG_SCAN_LENGTH, 1);
    push_range(140);
    drain_block();

    // Saturated length: a long run that the oversized length does not cut.
    in_idle_max  = 0;
    out_idle_max = 3;
    write_reg(REG_SCAN_LENGTH, LENGTH_MAX);
    write_reg(REG_START_ANGLE, ANG_FIELD_MIN);
    write_reg(REG_ANGLE_STEP, 1024);
    write_reg(REG_NEAR_THRESHOLD, RANGE_MAX);
    push_random_ranges(LONG_RUN);
    drain_block();

    // Steepest falling step over a long run of the same scan.
    write_reg(REG_SCAN_LENGTH, FULL_SCAN);
    write_reg(REG_ANGLE_STEP, STEP_MIN);
    write_reg(REG_NEAR_THRESHOLD, 2000);
    push_random_ranges(LONG_RUN);
    drain_block();

    // Random settings and random idling; one phase gets a long receiver stall.
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      randomize_settings();
      if (phase == HOLD_PHASE) begin
        write_reg(REG_WINDOW_LOW, ANG_FIELD_MIN);
        write_reg(REG_WINDOW_HIGH, ANG_FIELD_MAX);
        in_idle_max  = 0;
        out_idle_max = 0;
      end else begin
        in_idle_max  = pick_idle();
        out_idle_max = pick_idle();
      end
      count = $urandom_range(20, 90);
      push_random_ranges(count);
      if (phase == HOLD_PHASE) hold_requests++;
      random_sent += count;
      phase++;
      drain_block();
    end

    $display("run covered %0d range beats, %0d register writes, %0d random phases",
             samples_sent, reg_writes, phase);
    $display("checked %0d result beats, %0d with the obstacle flag, %0d errors",
             results_seen, obstacles_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lrmnd_pkg.sv
design/lrmnd_stream_if.sv
design/lrmnd_cell.sv
design/lrmnd_regs.sv
design/lidar_recursive_mean_near_detect.sv
sim/lidar_recursive_mean_near_detect_tb.sv
